[rtl/active_expired_priority_queues_assert.svh]
// Assertion macros used by the scheduler's queue controller (aepq_ctrl).
`ifndef ACTIVE_EXPIRED_PRIORITY_QUEUES_ASSERT_SVH
`define ACTIVE_EXPIRED_PRIORITY_QUEUES_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define AEPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define AEPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/aepq_pkg.sv]
// Types, constants and helpers for the active/expired priority queue scheduler.
package aepq_pkg;

  localparam int MAX_LEVELS    = 16;
  localparam int QUEUE_DEPTH   = 16;   // power of two: slot pointers wrap by truncation
  localparam int TASK_ID_COUNT = 256;

  localparam int NUM_QUEUES = 2 * MAX_LEVELS;
  localparam int LEVEL_W    = $clog2(MAX_LEVELS);
  localparam int QID_W      = $clog2(NUM_QUEUES);
  localparam int PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int TASK_W     = $clog2(TASK_ID_COUNT);
  localparam int SLOT_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);

  // Fixed field widths of the command and result beats
  localparam int CMD_W      = 2;
  localparam int IN_TASK_W  = 8;
  localparam int IN_LEVEL_W = 4;
  localparam int STATUS_W   = 3;
  localparam int CFG_W      = 5;
  localparam logic [CFG_W-1:0] LEVELS_RESET = CFG_W'(4);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_ACTIVE  = 2'd0,
    CMD_ADD_EXPIRED = 2'd1,
    CMD_DISPATCH    = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED      = 3'd0,
    ST_FULL       = 3'd1,
    ST_BAD_LEVEL  = 3'd2,
    ST_DISPATCHED = 3'd3,
    ST_NONE       = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t                  command;
    logic [IN_TASK_W-1:0]  task_id;
    logic [IN_LEVEL_W-1:0] level;
  } cmd_beat_t;

  typedef struct packed {
    status_t               status;
    logic [IN_TASK_W-1:0]  chosen_task;
    logic [IN_LEVEL_W-1:0] chosen_level;
  } result_t;

  // Slot memory access issued by the queue controller
  typedef struct packed {
    logic               we;
    logic [SLOT_AW-1:0] waddr;
    logic [TASK_W-1:0]  wdata;
    logic               re;
    logic [SLOT_AW-1:0] raddr;
  } slot_req_t;

  // Registered response; task comes from the slot memory when from_ram is set
  typedef struct packed {
    logic                 done;
    status_t              status;
    logic [LEVEL_W-1:0]   level;
    logic                 from_ram;
  } resp_t;

  // Index of the highest set bit (zero when none is set)
  function automatic logic [LEVEL_W-1:0] highest_set(input logic [MAX_LEVELS-1:0] vec);
    logic [LEVEL_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (vec[i]) idx = LEVEL_W'(i);
    end
    return idx;
  endfunction

endpackage

[rtl/active_expired_priority_queues.sv]
// Latency: the result strobe (done) rises the cycle after start is accepted.
// Throughput: one command per cycle outside reset; the registered read of the slot
// memory sets the latency, and queue state updates at the accepting edge.
// busy is high only while rst is asserted; results cannot be stalled.
// Reset clears queue heads and counts, the bank bit, and sets levels_in_use to 4;
// the slot memory is not cleared, since only counted entries are ever read.
module active_expired_priority_queues
  import aepq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  cmd_beat_t   cmd,
  output logic        done,
  output result_t     result,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             accept;
  logic [CFG_W-1:0] levels_in_use;
  logic             reg_hit;
  slot_req_t        slot;
  resp_t            resp;
  logic [TASK_W-1:0] slot_rdata;

  assign busy   = rst;
  assign accept = start && !busy;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'b0);
  assign prdata  = reg_hit ? {{(32 - CFG_W){1'b0}}, levels_in_use} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      levels_in_use <= LEVELS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      levels_in_use <= pwdata[CFG_W-1:0];
    end
  end

  aepq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .cmd           (cmd),
    .levels_in_use (levels_in_use),
    .slot          (slot),
    .resp          (resp)
  );

  aepq_ram #(
    .WIDTH (TASK_W),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot.we),
    .waddr (slot.waddr),
    .wdata (slot.wdata),
    .re    (slot.re),
    .raddr (slot.raddr),
    .rdata (slot_rdata)
  );

  // Result beat
  assign done                = resp.done;
  assign result.status       = resp.status;
  assign result.chosen_task  = resp.from_ram ? IN_TASK_W'(slot_rdata) : '0;
  assign result.chosen_level = IN_LEVEL_W'(resp.level);

endmodule

[rtl/aepq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module aepq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

[rtl/aepq_ctrl.sv]
// Queue controller: head/count bookkeeping, bank swap and level search.
`include "active_expired_priority_queues_assert.svh"

module aepq_ctrl
  import aepq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  cmd_beat_t        cmd,
  input  logic [CFG_W-1:0] levels_in_use,
  output slot_req_t        slot,
  output resp_t            resp
);

  logic [PTR_W-1:0] head  [NUM_QUEUES];
  logic [CNT_W-1:0] count [NUM_QUEUES];
  logic             bank;

  logic [CFG_W-1:0]      lim;
  logic [MAX_LEVELS-1:0] level_mask;
  logic [MAX_LEVELS-1:0] ne_act;
  logic [MAX_LEVELS-1:0] ne_exp;
  logic                  found_act;
  logic                  found_exp;
  logic [LEVEL_W-1:0]    lvl_in;
  logic [QID_W-1:0]      qsel;
  logic [PTR_W-1:0]      head_cur;
  logic [CNT_W-1:0]      cnt_cur;
  logic [PTR_W-1:0]      head_next;
  logic [CNT_W-1:0]      count_next;
  logic                  upd;
  logic                  swap;
  logic                  do_we;
  logic                  do_re;
  status_t               status_next;
  logic [LEVEL_W-1:0]    level_next;
  logic                  pop_bank;
  logic [LEVEL_W-1:0]    pop_lvl;

  // Effective level count and the in-use mask
  always_comb begin
    lim = (levels_in_use > CFG_W'(MAX_LEVELS)) ? CFG_W'(MAX_LEVELS) : levels_in_use;
    for (int l = 0; l < MAX_LEVELS; l++) begin
      level_mask[l] = CFG_W'(l) < lim;
      ne_act[l] = (count[{bank, LEVEL_W'(l)}] != '0) && level_mask[l];
      ne_exp[l] = (count[{~bank, LEVEL_W'(l)}] != '0) && level_mask[l];
    end
  end

  assign found_act = |ne_act;
  assign found_exp = |ne_exp;
  assign lvl_in    = cmd.level[LEVEL_W-1:0];

  // Pop from the active bank, or after a swap from the former expired bank
  assign pop_bank = found_act ? bank : ~bank;
  assign pop_lvl  = found_act ? highest_set(ne_act) : highest_set(ne_exp);

  // Queue addressed by this command
  always_comb begin
    if (cmd.command == CMD_DISPATCH) begin
      qsel = {pop_bank, pop_lvl};
    end else if (cmd.command == CMD_ADD_ACTIVE) begin
      qsel = {bank, lvl_in};
    end else begin
      qsel = {~bank, lvl_in};
    end
  end

  assign head_cur = head[qsel];
  assign cnt_cur  = count[qsel];

  // Command decode
  always_comb begin
    upd         = 1'b0;
    swap        = 1'b0;
    do_we       = 1'b0;
    do_re       = 1'b0;
    head_next   = head_cur;
    count_next  = cnt_cur;
    status_next = ST_NONE;
    level_next  = '0;
    unique case (cmd.command) inside
      CMD_ADD_ACTIVE, CMD_ADD_EXPIRED: begin
        if (CFG_W'(cmd.level) >= lim) begin
          status_next = ST_BAD_LEVEL;
        end else if (cnt_cur == CNT_W'(QUEUE_DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_ADDED;
          do_we       = 1'b1;
          upd         = 1'b1;
          count_next  = cnt_cur + CNT_W'(1);
        end
      end
      CMD_DISPATCH: begin
        swap = ~found_act;
        if (found_act || found_exp) begin
          status_next = ST_DISPATCHED;
          level_next  = pop_lvl;
          do_re       = 1'b1;
          upd         = 1'b1;
          head_next   = head_cur + PTR_W'(1);
          count_next  = cnt_cur - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_NONE;
      end
    endcase
  end

  // Slot memory access: append at head+count, read at head
  always_comb begin
    slot.we    = accept && do_we;
    slot.waddr = {qsel, PTR_W'(head_cur + cnt_cur[PTR_W-1:0])};
    slot.wdata = cmd.task_id[TASK_W-1:0];
    slot.re    = accept && do_re;
    slot.raddr = {qsel, head_cur};
  end

  // Queue state, bank bit and registered response
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head[q]  <= '0;
        count[q] <= '0;
      end
      bank      <= 1'b0;
      resp.done <= 1'b0;
    end else begin
      resp.done <= accept;
      if (accept) begin
        resp.status   <= status_next;
        resp.level    <= level_next;
        resp.from_ram <= do_re;
        // swap empties the old active bank
        if (swap) begin
          for (int l = 0; l < MAX_LEVELS; l++) begin
            head[{bank, LEVEL_W'(l)}]  <= '0;
            count[{bank, LEVEL_W'(l)}] <= '0;
          end
          bank <= ~bank;
        end
        if (upd) begin
          head[qsel]  <= head_next;
          count[qsel] <= count_next;
        end
      end
    end
  end

  `AEPQ_ASSERT_NEXT(a_done_follows_accept, clk, rst, accept, resp.done, "no response after accepted command")
  `AEPQ_ASSERT_NEXT(a_no_spurious_done, clk, rst, !accept, !resp.done, "response without a command")
  `AEPQ_ASSERT_NEXT(a_swap_toggles_bank, clk, rst, accept && swap, bank != $past(bank), "swap did not toggle bank")
  `AEPQ_ASSERT_NEXT(a_bank_stable, clk, rst, !(accept && swap), $stable(bank), "bank changed without swap")
  `AEPQ_ASSERT_NOW(a_write_not_full, clk, rst, slot.we, cnt_cur != CNT_W'(QUEUE_DEPTH), "append to a full queue")

endmodule
